@@ rtl/cfa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contiguous frame allocator package
// Shared constants, codes and word types for the frame allocator.
// ----------------------------------------------------------------------------
package cfa_pkg;

   // Size of the frame map and width of a map index.
   localparam int unsigned FRAMES   = 8192;
   localparam int unsigned FRAME_AW = $clog2(FRAMES);
   localparam int unsigned FIELD_W  = 14;

   // Configuration register byte addresses.
   localparam logic [2:0] REG_KERNEL_FRAMES = 3'd0;
   localparam logic [2:0] REG_INFO_FRAME    = 3'd4;

   // Reset values of the configuration registers.
   localparam logic [FIELD_W-1:0] KERNEL_FRAMES_RST = 14'd1000;
   localparam logic [FIELD_W-1:0] INFO_FRAME_RST    = 14'd0;

   typedef enum logic [1:0] {
      OP_INIT    = 2'd0,
      OP_ALLOC   = 2'd1,
      OP_RELEASE = 2'd2,
      OP_RESERVE = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_NORUN   = 3'd1,
      ST_NOTHEAD = 3'd2,
      ST_BUSY    = 3'd3,
      ST_RANGE   = 3'd4
   } status_type;

   // Frame map entry codes.
   localparam logic [1:0] MAP_FREE  = 2'd0;
   localparam logic [1:0] MAP_HEAD  = 2'd1;
   localparam logic [1:0] MAP_ALLOC = 2'd2;

   typedef struct packed {
      opcode_type         opcode;
      logic [FIELD_W-1:0] first_frame;
      logic [FIELD_W-1:0] count;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] result_frame;
      status_type         status;
   } rsp_type;

endpackage

@@ rtl/contiguous_frame_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contiguous frame allocator
// First-fit allocator over a two-bit-per-frame map held in one RAM.
// ----------------------------------------------------------------------------
// Usage:
// A command word enters on req_ (valid/ready) and exactly one response word
// leaves on rsp_ (valid/ready). Commands are init, allocate, release and
// reserve. kernel_frames and info_frame are to be written on the csr_ port only
// while the block is idle; the block itself does not enforce this. init uses them.
// One command is worked at a time, and the map RAM (one read and one write
// port, one entry per cycle) sets the pace:
//   init: one map write per entry, over the whole map.
//   allocate: a scan from entry 0 to where the first long enough free run
//     ends, then one mark write per frame of the run.
//   release: a read of the run from its head to its end or the end of the
//     map; reserve: a check of count entries, then a mark of them.
//   range errors: no map access.
// While the map is cleared to free after reset, req_ready stays low. A
// finished response sits in an output register; the next command is
// accepted while it waits, and that command's response is held back until
// the earlier one is taken.
// ----------------------------------------------------------------------------
module contiguous_frame_allocator
   import cfa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_SCAN, S_MARK, S_REL, S_CHECK, S_DONE
   } state_type;

   localparam logic [FRAME_AW-1:0] LAST_IDX = FRAME_AW'(FRAMES - 1);

   state_type           state_ff;
   logic [FIELD_W-1:0]  kernel_ff;
   logic [FIELD_W-1:0]  info_ff;
   logic                init_mode_ff;
   logic [FRAME_AW-1:0] rd_ptr_ff;
   logic [FRAME_AW-1:0] chk_idx_ff;
   logic                pend_ff;
   logic [FRAME_AW-1:0] mptr_ff;
   logic [FIELD_W-1:0]  left_ff;
   logic [FIELD_W-1:0]  cnt_ff;
   logic [FIELD_W-1:0]  run_ff;
   logic [FRAME_AW-1:0] start_ff;
   logic                first_ff;
   logic [FIELD_W-1:0]  res_ff;
   status_type          st_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;

   logic                mem_we;
   logic [FRAME_AW-1:0] mem_waddr;
   logic [1:0]          mem_wdata;
   logic [1:0]          mem_rdata;
   logic                csr_wr;
   logic                init_alloc;
   logic                out_free;
   logic [FRAME_AW-1:0] req_start;
   logic                alloc_bad;
   logic                fno_bad;
   logic                resv_bad;
   logic [FRAME_AW-1:0] found_start;

   cfa_ram #(.WIDTH(2), .DEPTH(FRAMES)) u_map (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (rd_ptr_ff),
      .rdata (mem_rdata)
   );

   // Configuration port decode.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr[2])
         REG_KERNEL_FRAMES[2]: csr_prdata = 32'(kernel_ff);
         default:              csr_prdata = 32'(info_ff);
      endcase
   end

   // Init pattern for one map entry: kernel frames and the info frame pair.
   always_comb begin
      init_alloc = (FIELD_W'(chk_idx_ff) < kernel_ff);
      if (info_ff != '0) begin
         if (FIELD_W'(chk_idx_ff) == info_ff ||
             FIELD_W'(chk_idx_ff) == info_ff - 14'd1) begin
            init_alloc = 1'b1;
         end
      end
   end

   // Command range checks.
   assign req_start = FRAME_AW'(req_data.first_frame - 14'd1);
   assign alloc_bad = (req_data.count == '0) || (32'(req_data.count) > FRAMES);
   assign fno_bad   = (req_data.first_frame == '0) ||
                      (32'(req_data.first_frame) > FRAMES);
   assign resv_bad  = fno_bad || (req_data.count == '0) ||
                      (32'(req_data.count) > FRAMES - (32'(req_data.first_frame) - 32'd1));

   // Head of the run that ends at the entry under check.
   assign found_start = chk_idx_ff - FRAME_AW'(cnt_ff - 14'd1);

   // Map write port.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = chk_idx_ff;
      mem_wdata = MAP_FREE;
      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = (init_mode_ff && init_alloc) ? MAP_ALLOC : MAP_FREE;
         end
         S_MARK: begin
            mem_we    = 1'b1;
            mem_waddr = mptr_ff;
            mem_wdata = first_ff ? MAP_HEAD : MAP_ALLOC;
         end
         S_REL: begin
            mem_we = pend_ff && (first_ff ? (mem_rdata == MAP_HEAD)
                                          : (mem_rdata == MAP_ALLOC));
         end
         default: mem_we = 1'b0;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff <= KERNEL_FRAMES_RST;
         info_ff   <= INFO_FRAME_RST;
      end else if (csr_wr) begin
         if (csr_paddr[2] == REG_INFO_FRAME[2]) begin
            info_ff <= csr_pwdata[FIELD_W-1:0];
         end else begin
            kernel_ff <= csr_pwdata[FIELD_W-1:0];
         end
      end
   end

   // Command sequencer and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         init_mode_ff <= 1'b0;
         chk_idx_ff   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         // Streaming read pointer used by the scan states.
         pend_ff    <= 1'b1;
         rd_ptr_ff  <= rd_ptr_ff + 1'b1;
         chk_idx_ff <= rd_ptr_ff;

         unique case (state_ff)
            S_CLEAR: begin
               chk_idx_ff <= chk_idx_ff + 1'b1;
               if (chk_idx_ff == LAST_IDX) begin
                  state_ff <= init_mode_ff ? S_DONE : S_IDLE;
               end
            end
            S_IDLE: begin
               pend_ff <= 1'b0;
               res_ff  <= '0;
               st_ff   <= ST_OK;
               cnt_ff  <= req_data.count;
               left_ff <= req_data.count;
               run_ff  <= '0;
               first_ff <= 1'b1;
               start_ff <= req_start;
               if (req_valid) begin
                  unique case (req_data.opcode)
                     OP_INIT: begin
                        init_mode_ff <= 1'b1;
                        chk_idx_ff   <= '0;
                        state_ff     <= S_CLEAR;
                     end
                     OP_ALLOC: begin
                        rd_ptr_ff <= '0;
                        if (alloc_bad) begin
                           st_ff    <= ST_RANGE;
                           state_ff <= S_DONE;
                        end else begin
                           state_ff <= S_SCAN;
                        end
                     end
                     OP_RELEASE: begin
                        rd_ptr_ff <= req_start;
                        if (fno_bad) begin
                           st_ff    <= ST_RANGE;
                           state_ff <= S_DONE;
                        end else begin
                           state_ff <= S_REL;
                        end
                     end
                     default: begin
                        rd_ptr_ff <= req_start;
                        if (resv_bad) begin
                           st_ff    <= ST_RANGE;
                           state_ff <= S_DONE;
                        end else begin
                           state_ff <= S_CHECK;
                        end
                     end
                  endcase
               end
            end
            S_SCAN: begin
               if (pend_ff) begin
                  if (mem_rdata == MAP_FREE) begin
                     run_ff <= run_ff + 14'd1;
                  end else begin
                     run_ff <= '0;
                  end
                  if (mem_rdata == MAP_FREE && run_ff + 14'd1 == cnt_ff) begin
                     mptr_ff  <= found_start;
                     res_ff   <= FIELD_W'(found_start) + 14'd1;
                     state_ff <= S_MARK;
                  end else if (chk_idx_ff == LAST_IDX) begin
                     st_ff    <= ST_NORUN;
                     state_ff <= S_DONE;
                  end
               end
            end
            S_MARK: begin
               mptr_ff  <= mptr_ff + 1'b1;
               left_ff  <= left_ff - 14'd1;
               first_ff <= 1'b0;
               if (left_ff == 14'd1) begin
                  state_ff <= S_DONE;
               end
            end
            S_REL: begin
               if (pend_ff) begin
                  first_ff <= 1'b0;
                  if (first_ff && mem_rdata != MAP_HEAD) begin
                     st_ff    <= ST_NOTHEAD;
                     state_ff <= S_DONE;
                  end else if (!first_ff && mem_rdata != MAP_ALLOC) begin
                     state_ff <= S_DONE;
                  end else if (chk_idx_ff == LAST_IDX) begin
                     state_ff <= S_DONE;
                  end
               end
            end
            S_CHECK: begin
               if (pend_ff) begin
                  left_ff <= left_ff - 14'd1;
                  if (mem_rdata != MAP_FREE) begin
                     st_ff    <= ST_BUSY;
                     state_ff <= S_DONE;
                  end else if (left_ff == 14'd1) begin
                     mptr_ff  <= start_ff;
                     left_ff  <= cnt_ff;
                     state_ff <= S_MARK;
                  end
               end
            end
            S_DONE: begin
               init_mode_ff <= 1'b0;
               if (out_free) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_ff.result_frame <= res_ff;
                  rsp_ff.status       <= st_ff;
                  state_ff            <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

@@ rtl/cfa_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cfa_ram #(
   parameter int unsigned WIDTH = 2,
   parameter int unsigned DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

@@ rtl/cfa_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame allocator port checker
// Watches the top-level ports of the frame allocator over time.
// ----------------------------------------------------------------------------
module cfa_checker
   import cfa_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A waiting response word is not withdrawn.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   // The map is being cleared right after reset, so no command is taken.
   a_reset_busy: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("command accepted during map clear");

   // A nonzero frame number comes only with success.
   a_frame_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_frame != '0 |-> rsp_data.status == ST_OK)
      else $error("frame number returned with failure status");

   // Only defined status codes appear.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= ST_RANGE)
      else $error("undefined status code");

endmodule

bind contiguous_frame_allocator cfa_checker u_cfa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

@@ sim/cfa_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame allocator checker
// Watches the command, response and register ports of the frame allocator,
// keeps its own copy of the frame map and registers, predicts one response
// word per accepted command and compares it with the words that leave.
// ----------------------------------------------------------------------------
module cfa_monitor
   import cfa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending
);

   logic [1:0]         shadow_map [FRAMES];
   logic [FIELD_W-1:0] kernel_count;
   logic [FIELD_W-1:0] info_index;
   rsp_type            awaited_rsp [$];

   // Marks a run: head first, body frames after it.
   task automatic mark_frames(input int start, input int n);
      for (int k = 0; k < n; k++)
         shadow_map[start + k] = (k == 0) ? MAP_HEAD : MAP_ALLOC;
   endtask

   // Applies one command to the shadow map and returns the response word.
   task automatic apply_command(input req_type cmd, output rsp_type word);
      int fno;
      int cnt;
      int run;
      int start;
      bit found;
      bit busy;
      int k;
      fno = cmd.first_frame;
      cnt = cmd.count;
      word.result_frame = '0;
      word.status = ST_OK;
      case (cmd.opcode)
         OP_INIT: begin
            for (k = 0; k < FRAMES; k++)
               shadow_map[k] = (k < kernel_count) ? MAP_ALLOC : MAP_FREE;
            if (info_index != 0) begin
               if (info_index - 1 < FRAMES) shadow_map[info_index - 1] = MAP_ALLOC;
               if (info_index < FRAMES) shadow_map[info_index] = MAP_ALLOC;
            end
         end
         OP_ALLOC: begin
            if (cnt == 0 || cnt > FRAMES) begin
               word.status = ST_RANGE;
            end else begin
               run = 0;
               found = 0;
               start = 0;
               for (k = 0; k < FRAMES && !found; k++) begin
                  run = (shadow_map[k] == MAP_FREE) ? run + 1 : 0;
                  if (run == cnt) begin
                     start = k + 1 - cnt;
                     found = 1;
                  end
               end
               if (found) begin
                  mark_frames(start, cnt);
                  word.result_frame = FIELD_W'(start + 1);
               end else begin
                  word.status = ST_NORUN;
               end
            end
         end
         OP_RELEASE: begin
            if (fno == 0 || fno > FRAMES) begin
               word.status = ST_RANGE;
            end else if (shadow_map[fno - 1] != MAP_HEAD) begin
               word.status = ST_NOTHEAD;
            end else begin
               shadow_map[fno - 1] = MAP_FREE;
               for (k = fno; k < FRAMES && shadow_map[k] == MAP_ALLOC; k++)
                  shadow_map[k] = MAP_FREE;
            end
         end
         default: begin
            if (fno == 0 || fno > FRAMES || cnt == 0 || cnt > FRAMES - (fno - 1)) begin
               word.status = ST_RANGE;
            end else begin
               busy = 0;
               for (k = 0; k < cnt; k++)
                  if (shadow_map[fno - 1 + k] != MAP_FREE) busy = 1;
               if (busy) word.status = ST_BUSY;
               else mark_frames(fno - 1, cnt);
            end
         end
      endcase
   endtask

   // Tracks register writes, predicts accepted commands, checks responses.
   always @(posedge clock) begin : monitor
      rsp_type want;
      rsp_type got;
      int bad;
      bad = 0;
      if (reset) begin
         for (int k = 0; k < FRAMES; k++) shadow_map[k] = MAP_FREE;
         kernel_count = KERNEL_FRAMES_RST;
         info_index = INFO_FRAME_RST;
         awaited_rsp.delete();
         fail_count <= 0;
         pending <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == REG_KERNEL_FRAMES) kernel_count = csr_pwdata[FIELD_W-1:0];
            else if (csr_paddr == REG_INFO_FRAME) info_index = csr_pwdata[FIELD_W-1:0];
         end
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (awaited_rsp.size() == 0) begin
               $error("response word with nothing expected: result_frame %0d status %0d",
                      got.result_frame, got.status);
               bad++;
            end else begin
               want = awaited_rsp.pop_front();
               if (got.result_frame !== want.result_frame) begin
                  $error("result_frame mismatch: expected %0d, actual %0d",
                         want.result_frame, got.result_frame);
                  bad++;
               end
               if (got.status !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         want.status, got.status);
                  bad++;
               end
            end
         end
         if (req_valid && req_ready) begin
            apply_command(req_data, want);
            awaited_rsp.push_back(want);
         end
         fail_count <= fail_count + bad;
         pending <= awaited_rsp.size();
      end
   end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame allocator testbench
// Drives directed and random commands through the allocator with random
// gaps and response stalls, reprograms the registers between phases, and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb;
   import cfa_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          pending;
   bit          steady;
   int          live_heads [$];

   contiguous_frame_allocator DUT (.*);

   cfa_monitor u_monitor (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_pready(csr_pready),
      .fail_count(fail_count), .pending(pending)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Gap length: mostly none or short, now and then long.
   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (steady || pick < 55) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Response stalls on the receiving side.
   always @(posedge clock) begin : stall_gen
      int hold;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold = 0;
      end else if (hold > 0) begin
         hold--;
         rsp_ready <= 1'b0;
      end else begin
         hold = gap_length();
         rsp_ready <= (hold == 0);
      end
   end

   // Remember heads handed out so most releases name a real run.
   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready && rsp_data.status == ST_OK &&
          rsp_data.result_frame != 0)
         live_heads.push_back(rsp_data.result_frame);

   task automatic send_cmd(input opcode_type op, input int fno, input int cnt);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data.opcode <= op;
      req_data.first_frame <= FIELD_W'(fno);
      req_data.count <= FIELD_W'(cnt);
      do @(posedge clock); while (!req_ready);
   endtask

   // Waits until every response has come, then idles before returning.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] addr, input int value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= {18'($urandom_range(0, 262143)), FIELD_W'(value)};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // One random command: mostly well-formed, some noise.
   task automatic random_cmd();
      int pick;
      int idx;
      int fno;
      pick = $urandom_range(0, 99);
      if (pick < 42) begin
         send_cmd(OP_ALLOC, $urandom_range(0, 16383),
                  ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8));
      end else if (pick < 72) begin
         if (live_heads.size() > 0) begin
            idx = $urandom_range(0, live_heads.size() - 1);
            fno = live_heads[idx];
            live_heads.delete(idx);
         end else begin
            fno = $urandom_range(1, 1200);
         end
         send_cmd(OP_RELEASE, fno, $urandom_range(0, 16383));
      end else if (pick < 88) begin
         send_cmd(OP_RESERVE, ($urandom_range(0, 1) == 1) ? $urandom_range(1, 1200)
                  : $urandom_range(1, 8192), $urandom_range(1, 8));
      end else if (pick < 93) begin
         // Oversize counts are refused at once, except exactly the map size.
         send_cmd(OP_ALLOC, $urandom_range(0, 16383), $urandom_range(8193, 16383));
      end else begin
         send_cmd(($urandom_range(0, 1) == 1) ? OP_RELEASE : OP_RESERVE,
                  $urandom_range(0, 16383), $urandom_range(0, 16383));
      end
   endtask

   initial begin
      #600_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      int kern [8] = '{0, 8192, 16383, 3, 40, 7, 100, 1000};
      int info [8] = '{0, 8192, 16383, 1, 8191, 8192, 50, 0};
      int items;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      steady = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: range checks, full map, release stops, reserve limits.
      send_cmd(OP_ALLOC, 0, 1);
      send_cmd(OP_ALLOC, 0, 0);
      send_cmd(OP_ALLOC, 0, 8193);
      send_cmd(OP_ALLOC, 16383, 16383);
      send_cmd(OP_ALLOC, 0, 8192);
      send_cmd(OP_RELEASE, 0, 0);
      send_cmd(OP_RELEASE, 8193, 0);
      send_cmd(OP_RELEASE, 16383, 0);
      send_cmd(OP_RELEASE, 1, 0);
      send_cmd(OP_ALLOC, 0, 8192);
      send_cmd(OP_RELEASE, 2, 0);
      send_cmd(OP_RELEASE, 1, 0);
      send_cmd(OP_RESERVE, 8192, 1);
      send_cmd(OP_RESERVE, 8192, 2);
      send_cmd(OP_RESERVE, 8191, 2);
      send_cmd(OP_RESERVE, 0, 1);
      send_cmd(OP_RESERVE, 5, 0);
      send_cmd(OP_RELEASE, 8192, 0);
      send_cmd(OP_RESERVE, 10, 4);
      send_cmd(OP_RESERVE, 14, 2);
      send_cmd(OP_RELEASE, 10, 0);
      send_cmd(OP_RELEASE, 14, 0);
      send_cmd(OP_RESERVE, 1, 8192);
      send_cmd(OP_INIT, 0, 0);
      send_cmd(OP_ALLOC, 0, 3);
      drain();

      // Random phases, one per register setting.
      for (int ph = 0; ph < 8; ph++) begin
         write_reg(REG_KERNEL_FRAMES, kern[ph]);
         write_reg(REG_INFO_FRAME, info[ph]);
         live_heads.delete();
         steady = (ph == 3);
         send_cmd(OP_INIT, $urandom_range(0, 16383), $urandom_range(0, 16383));
         items = (kern[ph] >= 8192) ? 15 : 150;
         for (int n = 0; n < items; n++) begin
            random_cmd();
            if (n == items / 2 && ph == 4) drain();
         end
         drain();
      end
      steady = 1'b0;

      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
